### design/ctse_pkg.sv
// ----------------------------------------------------------------------------
// ctse_pkg: calendar time set editor definitions
// Action codes, field bounds and month length lookup.
// ----------------------------------------------------------------------------
package ctse_pkg;

  typedef enum logic [2:0] {
    ACT_MODE = 3'd0,
    ACT_NEXT = 3'd1,
    ACT_INC  = 3'd2,
    ACT_DEC  = 3'd3,
    ACT_TICK = 3'd4,
    ACT_LOAD = 3'd5
  } action_t;

  localparam int unsigned NUM_FIELDS = 6;

  localparam logic [6:0] YEAR_MAX   = 7'd99;
  localparam logic [3:0] MONTH_MAX  = 4'd12;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;
  localparam logic [2:0] SEL_LAST   = 3'(NUM_FIELDS - 1);

  localparam logic [9:0] BLINK_PERIOD_RST = 10'd500;

  // month length, 0 for an invalid month
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

### design/calendar_time_set_editor_core.sv
// ----------------------------------------------------------------------------
// calendar_time_set_editor_core: calendar time set editor
// An accepted item goes through the input register, then the state and result
// registers, where its result is valid. Throughput one item per cycle unless
// out_stall holds the output, with a single state update stage. Synchronous
// active-low reset: time fields go to year 0, month 1, day 1, 00:00:00, show
// mode, blink period 500.
// ----------------------------------------------------------------------------
module calendar_time_set_editor_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [9:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_action,
  input  logic [6:0] in_load_year,
  input  logic [3:0] in_load_month,
  input  logic [4:0] in_load_day,
  input  logic [4:0] in_load_hour,
  input  logic [5:0] in_load_minute,
  input  logic [5:0] in_load_second,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_year,
  output logic [3:0] out_month,
  output logic [4:0] out_day,
  output logic [4:0] out_hour,
  output logic [5:0] out_minute,
  output logic [5:0] out_second,
  output logic       out_edit_mode,
  output logic [2:0] out_field_select,
  output logic [5:0] out_blank_mask,
  output logic       out_commit
);
  import ctse_pkg::*;

  logic [9:0] blink_period_r;

  // input register
  logic       in_vld_r;
  logic [2:0] act_r;
  logic [6:0] ld_year_r;
  logic [3:0] ld_month_r;
  logic [4:0] ld_day_r;
  logic [4:0] ld_hour_r;
  logic [5:0] ld_minute_r;
  logic [5:0] ld_second_r;

  // state
  logic [6:0] year_r, year_nxt;
  logic [3:0] month_r, month_nxt;
  logic [4:0] day_r, day_nxt;
  logic [4:0] hour_r, hour_nxt;
  logic [5:0] minute_r, minute_nxt;
  logic [5:0] second_r, second_nxt;
  logic       mode_r, mode_nxt;
  logic [2:0] sel_r, sel_nxt;
  logic       blink_r, blink_nxt;
  logic [9:0] tick_r, tick_nxt;

  // result
  logic       out_vld_r;
  logic [5:0] blank_r, blank_nxt;
  logic       commit_r, commit_nxt;

  logic adv;
  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !adv;

  // adjust datapath
  logic [5:0] inc_hot, dec_hot;
  logic [7:0] y_up;
  logic [6:0] y_up_c, y_dn_c;
  logic [4:0] m_up;
  logic [3:0] m_up_c, m_dn_c;
  logic [4:0] len_up, len_dn;
  logic [5:0] d_up;
  logic [4:0] d_up_c, d_dn, d_dn_c;
  logic       d_lt1;
  logic [5:0] h_up;
  logic [4:0] h_up_c, h_dn_c;
  logic [6:0] mi_up, s_up;
  logic [5:0] mi_up_c, mi_dn_c, s_up_c, s_dn_c;

  always_comb begin
    for (int i = 0; i < NUM_FIELDS; i++) begin
      inc_hot[i] = (sel_r == 3'(i));
    end
    dec_hot = inc_hot;

    // increment path
    y_up   = {1'b0, year_r} + {7'd0, inc_hot[0]};
    y_up_c = (y_up > {1'b0, YEAR_MAX}) ? 7'd0 : y_up[6:0];
    m_up   = {1'b0, month_r} + {4'd0, inc_hot[1]};
    m_up_c = (m_up > {1'b0, MONTH_MAX}) ? 4'd1 : m_up[3:0];
    len_up = month_len(m_up_c, y_up_c[1:0] == 2'd0);
    d_up   = {1'b0, day_r} + {5'd0, inc_hot[2]};
    d_up_c = (len_up != 5'd0 && d_up > {1'b0, len_up}) ? 5'd1 : d_up[4:0];
    h_up   = {1'b0, hour_r} + {5'd0, inc_hot[3]};
    h_up_c = (h_up > {1'b0, HOUR_MAX}) ? 5'd0 : h_up[4:0];
    mi_up  = {1'b0, minute_r} + {6'd0, inc_hot[4]};
    mi_up_c = (mi_up > {1'b0, MINSEC_MAX}) ? 6'd0 : mi_up[5:0];
    s_up   = {1'b0, second_r} + {6'd0, inc_hot[5]};
    s_up_c = (s_up > {1'b0, MINSEC_MAX}) ? 6'd0 : s_up[5:0];

    // decrement path
    y_dn_c = (dec_hot[0] && year_r == 7'd0) ? YEAR_MAX : year_r - {6'd0, dec_hot[0]};
    m_dn_c = (month_r == 4'd0 || (dec_hot[1] && month_r == 4'd1)) ? MONTH_MAX :
             month_r - {3'd0, dec_hot[1]};
    len_dn = month_len(m_dn_c, y_dn_c[1:0] == 2'd0);
    d_dn   = day_r - {4'd0, dec_hot[2]};
    d_lt1  = (day_r == 5'd0) || (dec_hot[2] && day_r == 5'd1);
    if (len_dn == 5'd0) begin
      d_dn_c = d_dn;
    end else if (d_lt1) begin
      d_dn_c = len_dn;
    end else if (d_dn > len_dn) begin
      d_dn_c = 5'd1;
    end else begin
      d_dn_c = d_dn;
    end
    h_dn_c  = (dec_hot[3] && hour_r == 5'd0) ? HOUR_MAX : hour_r - {4'd0, dec_hot[3]};
    mi_dn_c = (dec_hot[4] && minute_r == 6'd0) ? MINSEC_MAX :
              minute_r - {5'd0, dec_hot[4]};
    s_dn_c  = (dec_hot[5] && second_r == 6'd0) ? MINSEC_MAX :
              second_r - {5'd0, dec_hot[5]};
  end

  // next state
  always_comb begin
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    mode_nxt   = mode_r;
    sel_nxt    = sel_r;
    blink_nxt  = blink_r;
    tick_nxt   = tick_r;
    commit_nxt = 1'b0;
    case (act_r)
      ACT_MODE: begin
        if (!mode_r) begin
          mode_nxt = 1'b1;
          sel_nxt  = 3'd0;
        end else begin
          mode_nxt   = 1'b0;
          commit_nxt = 1'b1;
        end
      end
      ACT_NEXT: begin
        if (mode_r) begin
          sel_nxt = (sel_r >= SEL_LAST) ? 3'd0 : sel_r + 3'd1;
        end
      end
      ACT_INC: begin
        if (mode_r && sel_r <= SEL_LAST) begin
          year_nxt   = y_up_c;
          month_nxt  = m_up_c;
          day_nxt    = d_up_c;
          hour_nxt   = h_up_c;
          minute_nxt = mi_up_c;
          second_nxt = s_up_c;
        end
      end
      ACT_DEC: begin
        if (mode_r && sel_r <= SEL_LAST) begin
          year_nxt   = y_dn_c;
          month_nxt  = m_dn_c;
          day_nxt    = d_dn_c;
          hour_nxt   = h_dn_c;
          minute_nxt = mi_dn_c;
          second_nxt = s_dn_c;
        end
      end
      ACT_TICK: begin
        tick_nxt = tick_r + 10'd1;
        if (tick_nxt >= blink_period_r) begin
          tick_nxt  = 10'd0;
          blink_nxt = !blink_r;
        end
      end
      ACT_LOAD: begin
        if (!mode_r) begin
          year_nxt   = ld_year_r;
          month_nxt  = ld_month_r;
          day_nxt    = ld_day_r;
          hour_nxt   = ld_hour_r;
          minute_nxt = ld_minute_r;
          second_nxt = ld_second_r;
        end
      end
      default: begin
      end
    endcase
    blank_nxt = (mode_nxt && blink_nxt && sel_nxt <= SEL_LAST) ? (6'd1 << sel_nxt) : 6'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_period_r <= BLINK_PERIOD_RST;
    end else if (cfg_we) begin
      blink_period_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      act_r       <= in_action;
      ld_year_r   <= in_load_year;
      ld_month_r  <= in_load_month;
      ld_day_r    <= in_load_day;
      ld_hour_r   <= in_load_hour;
      ld_minute_r <= in_load_minute;
      ld_second_r <= in_load_second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r    <= 7'd0;
      month_r   <= 4'd1;
      day_r     <= 5'd1;
      hour_r    <= 5'd0;
      minute_r  <= 6'd0;
      second_r  <= 6'd0;
      mode_r    <= 1'b0;
      sel_r     <= 3'd0;
      blink_r   <= 1'b0;
      tick_r    <= 10'd0;
      out_vld_r <= 1'b0;
      blank_r   <= 6'd0;
      commit_r  <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
      if (in_vld_r) begin
        year_r   <= year_nxt;
        month_r  <= month_nxt;
        day_r    <= day_nxt;
        hour_r   <= hour_nxt;
        minute_r <= minute_nxt;
        second_r <= second_nxt;
        mode_r   <= mode_nxt;
        sel_r    <= sel_nxt;
        blink_r  <= blink_nxt;
        tick_r   <= tick_nxt;
        blank_r  <= blank_nxt;
        commit_r <= commit_nxt;
      end
    end
  end

  assign out_valid        = out_vld_r;
  assign out_year         = year_r;
  assign out_month        = month_r;
  assign out_day          = day_r;
  assign out_hour         = hour_r;
  assign out_minute       = minute_r;
  assign out_second       = second_r;
  assign out_edit_mode    = mode_r;
  assign out_field_select = sel_r;
  assign out_blank_mask   = blank_r;
  assign out_commit       = commit_r;

endmodule
